### src/sgcd_pkg.sv
`default_nettype none

package sgcd_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    // child positions run up to 127, child length up to 128
    localparam int POS_W = 7;
    localparam int LEN_W = 8;

    localparam logic [1:0] CODE_GAP = 2'd0;
    localparam logic [1:0] CODE_IRR = 2'd1;
    localparam logic [1:0] CODE_RED = 2'd2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_GEN  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN
    } t_state;

endpackage

`default_nettype wire

### src/semigroup_child_decomposition.sv
`default_nettype none

// Child generation for one node of the numerical semigroup tree.
// Command channel: a word is taken at a rising edge where start is high
// and busy is low. operation 0 loads one parent table entry (code 3 is
// stored as 2); it gives no result and busy stays low. operation 1
// removes generator removed_generator from the loaded parent and builds
// the child table.
// Result channel: one word per child position 0..L-1, L = x+1+m', each on
// the o_ ports for one cycle with o_strobe high; the last word has
// o_last_entry set and carries the child count. The receiver cannot
// stall the block and every word must be taken when shown.
// Timing: a generate holds busy through the PREP state and the RUN
// state, one table position per cycle through a single shift-and-compare
// test of the membership bitmap against the irreducible bitmap; each
// RUN step is registered into the result word, one word per cycle. A
// child that does not fit the table gives one overflow word the cycle
// after the accept, with busy staying low.
// Reset clears the sequencer and the result strobe; table contents are
// kept only by loads and generate runs.
module semigroup_child_decomposition #(
    parameter int TABLE_DEPTH = sgcd_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       i_operation,
    input  wire logic [5:0] i_entry_index,
    input  wire logic [1:0] i_entry_value,
    input  wire logic [5:0] i_removed_generator,
    input  wire logic [5:0] i_parent_conductor,
    input  wire logic [5:0] i_parent_multiplicity,
    output logic            o_strobe,
    output logic [5:0]      o_child_index,
    output logic [1:0]      o_child_value,
    output logic [6:0]      o_child_conductor,
    output logic [6:0]      o_child_multiplicity,
    output logic [6:0]      o_child_count,
    output logic            o_last_entry,
    output logic            o_overflow
);
    import sgcd_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = LEN_W + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    t_state r_state, n_state;

    logic [1:0]             r_pmem [TABLE_DEPTH];
    logic [1:0]             r_pdata;
    logic [TABLE_DEPTH-1:0] r_memb;
    logic [TABLE_DEPTH-1:0] r_irr;

    logic [POS_W-1:0] r_pos;
    logic [5:0]       r_x;
    logic [6:0]       r_plen;
    logic [LEN_W-1:0] r_len;
    logic [6:0]       r_cond;
    logic [6:0]       r_mult;
    logic [6:0]       r_count;

    logic       r_strobe;
    logic [5:0] r_idx;
    logic [1:0] r_val;
    logic [6:0] r_ocond;
    logic [6:0] r_omult;
    logic [6:0] r_ocount;
    logic       r_last;
    logic       r_ovf;

    logic             acc;
    logic             step;
    logic [AW-1:0]    rd_addr;
    logic [6:0]       a_cond;
    logic [6:0]       a_mult;
    logic [LEN_W-1:0] a_len;
    logic             a_ovf;
    logic             load_ok;
    logic [1:0]       load_val;

    logic [AW-1:0]          pos_a;
    logic [AW-1:0]          shamt;
    logic [TABLE_DEPTH-1:0] rev;
    logic                   hit;
    logic [1:0]             v_par;
    logic [1:0]             code;
    logic                   new_irr;
    logic [6:0]             count_nxt;
    logic                   last_pos;

    // command decode
    always_comb begin
        acc      = start && !busy;
        a_cond   = {1'b0, i_removed_generator} + 7'd1;
        a_mult   = (i_removed_generator == i_parent_multiplicity)
                   ? ({1'b0, i_parent_multiplicity} + 7'd1)
                   : {1'b0, i_parent_multiplicity};
        a_len    = {1'b0, a_cond} + {1'b0, a_mult};
        a_ovf    = CW'(a_len) > DEPTH_C;
        load_ok  = CW'(i_entry_index) < DEPTH_C;
        load_val = (i_entry_value > CODE_RED) ? CODE_RED : i_entry_value;
    end

    // reducibility test for the current position
    always_comb begin
        pos_a = AW'(r_pos);
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            rev[k] = r_memb[TABLE_DEPTH-1-k];
        end
        shamt = LAST_ADDR - pos_a;
        hit   = |(r_irr & (rev >> shamt));
        v_par = (r_pos < r_plen) ? r_pdata : CODE_RED;
        if (r_pos < {1'b0, r_x}) begin
            code = r_pdata;
        end else if (r_pos == {1'b0, r_x}) begin
            code = CODE_GAP;
        end else if ((v_par == CODE_IRR) || !hit) begin
            code = CODE_IRR;
        end else begin
            code = CODE_RED;
        end
        new_irr   = (r_pos > {1'b0, r_x}) && (code == CODE_IRR);
        count_nxt = r_count + {6'd0, new_irr};
        last_pos  = ({1'b0, r_pos} == (r_len - 8'd1));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc && (i_operation == OP_GEN) && !a_ovf) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (last_pos) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        busy    = 1'b1;
        step    = 1'b0;
        rd_addr = '0;
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_PREP: begin
                rd_addr = '0;
            end
            ST_RUN: begin
                step    = 1'b1;
                rd_addr = AW'(r_pos + 7'd1);
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // parent table
    always_ff @(posedge i_clk) begin
        if (acc && (i_operation == OP_LOAD) && load_ok) begin
            r_pmem[AW'(i_entry_index)] <= load_val;
        end
        r_pdata <= r_pmem[rd_addr];
    end

    // run registers and child bitmaps
    always_ff @(posedge i_clk) begin
        if (acc && (i_operation == OP_GEN)) begin
            r_x     <= i_removed_generator;
            r_plen  <= {1'b0, i_parent_conductor} + {1'b0, i_parent_multiplicity};
            r_len   <= a_len;
            r_cond  <= a_cond;
            r_mult  <= a_mult;
            r_count <= '0;
            r_pos   <= '0;
            r_irr   <= '0;
        end else if (step) begin
            r_pos         <= r_pos + 7'd1;
            r_count       <= count_nxt;
            r_memb[pos_a] <= (code != CODE_GAP);
            if (code == CODE_IRR) begin
                r_irr[pos_a] <= 1'b1;
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= step || (acc && (i_operation == OP_GEN) && a_ovf);
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_idx    <= r_pos[5:0];
            r_val    <= code;
            r_ocond  <= r_cond;
            r_omult  <= r_mult;
            r_ocount <= last_pos ? count_nxt : 7'd0;
            r_last   <= last_pos;
            r_ovf    <= 1'b0;
        end else if (acc && (i_operation == OP_GEN)) begin
            r_idx    <= '0;
            r_val    <= CODE_GAP;
            r_ocond  <= a_cond;
            r_omult  <= a_mult;
            r_ocount <= '0;
            r_last   <= 1'b1;
            r_ovf    <= 1'b1;
        end
    end

    assign o_strobe             = r_strobe;
    assign o_child_index        = r_idx;
    assign o_child_value        = r_val;
    assign o_child_conductor    = r_ocond;
    assign o_child_multiplicity = r_omult;
    assign o_child_count        = r_ocount;
    assign o_last_entry         = r_last;
    assign o_overflow           = r_ovf;

endmodule

`default_nettype wire
